>>> src/srdt_pkg.sv
package srdt_pkg;

  localparam int NUM_EXECS_DEF   = 16;
  localparam int DEMAND_BITS_DEF = 16;

  localparam int IDX_IN_W = 4;
  localparam int DEM_IN_W = 16;
  localparam int MASK_W   = 16;
  localparam int TOTAL_W  = 20;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [MASK_W-1:0]  dest_mask;
    logic [TOTAL_W-1:0] total_demand;
    logic               notice_connected;
    logic               integrity_error;
    logic               last_notice;
  } notice_t;

endpackage

>>> src/srdt_ram.sv
module srdt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/shared_resource_demand_tracker.sv
// Shared resource demand tracker.
// Command channel: a status report (client_index, client_connected,
// client_demand) is taken at a rising edge with start high and busy low.
// busy is high in the cycle after each accepted transaction, so a new
// report cannot be taken while the last one is in progress; busy covers the
// demand memory read in the accept cycle and the state update in the next one.
// Result channel: each notice is on the result ports for one cycle with
// result_valid high. The first notice of a report is built from the input
// register and the stored state and registered in the result register;
// a second one (disconnect notice) follows in the next cycle.
// last_notice marks the final notice of a report. Reports that cause no
// notice (out-of-range index, nothing changed) produce no strobe.
// The receiver cannot stall; notices are never held back.
// Reset (rst, synchronous) clears the connected bits and the total. The
// demand memory needs no clearing: a stored demand only counts while the
// client's connected bit is set, and setting that bit writes the demand.
module shared_resource_demand_tracker #(
  parameter int NUM_EXECS   = srdt_pkg::NUM_EXECS_DEF,
  parameter int DEMAND_BITS = srdt_pkg::DEMAND_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [srdt_pkg::IDX_IN_W-1:0] client_index,
  input  logic                         client_connected,
  input  logic [srdt_pkg::DEM_IN_W-1:0] client_demand,
  output logic                         result_valid,
  output logic [srdt_pkg::MASK_W-1:0]  dest_mask,
  output logic [srdt_pkg::TOTAL_W-1:0] total_demand,
  output logic                         notice_connected,
  output logic                         integrity_error,
  output logic                         last_notice
);

  localparam int IDX_W  = $clog2(NUM_EXECS);
  localparam int SUM_W  = DEMAND_BITS + IDX_W;
  localparam int CMP_W  = (SUM_W > srdt_pkg::TOTAL_W) ? SUM_W : srdt_pkg::TOTAL_W;
  localparam int MASK_N = (NUM_EXECS < srdt_pkg::MASK_W) ? NUM_EXECS : srdt_pkg::MASK_W;

  // input register
  logic                          s1_valid;
  logic [srdt_pkg::IDX_IN_W-1:0] idx_r;
  logic                          conn_r;
  logic [DEMAND_BITS-1:0]        dem_r;
  logic                          in_range_r;

  // state
  logic [NUM_EXECS-1:0]          conn_bits;
  logic [SUM_W-1:0]              exact;
  logic [srdt_pkg::TOTAL_W-1:0]  total;
  logic [DEMAND_BITS-1:0]        rd_data;

  // result registers
  srdt_pkg::notice_t res;
  srdt_pkg::notice_t pend_n;
  logic              pend;

  logic accept;
  assign accept = start && !busy;
  assign busy   = s1_valid;

  logic [IDX_W-1:0] addr_r;
  assign addr_r = IDX_W'(idx_r);

  logic                         err;
  logic                         upd;
  logic                         prev;
  logic                         disc;
  logic [DEMAND_BITS-1:0]       old_dem;
  logic [DEMAND_BITS-1:0]       add_dem;
  logic [SUM_W-1:0]             exact_next;
  logic [CMP_W-1:0]             exact_ext;
  logic [srdt_pkg::TOTAL_W-1:0] sat;
  logic [NUM_EXECS-1:0]         conn_next;
  logic [srdt_pkg::MASK_W-1:0]  mask_all;
  logic [srdt_pkg::MASK_W-1:0]  own_bit;
  logic                         first_v;
  logic                         second_v;
  srdt_pkg::notice_t            first;
  srdt_pkg::notice_t            second;

  srdt_ram #(
    .WIDTH(DEMAND_BITS),
    .DEPTH(NUM_EXECS)
  ) u_dem_ram (
    .clk    (clk),
    .wr_en  (upd),
    .wr_addr(addr_r),
    .wr_data(dem_r),
    .rd_en  (accept),
    .rd_addr(IDX_W'(client_index)),
    .rd_data(rd_data)
  );

  always_comb begin
    err        = !conn_r && (dem_r != '0);
    upd        = s1_valid && in_range_r && !err;
    prev       = conn_bits[addr_r];
    disc       = prev && !conn_r;
    old_dem    = prev ? rd_data : '0;
    add_dem    = conn_r ? dem_r : '0;
    exact_next = exact - SUM_W'(old_dem) + SUM_W'(add_dem);
    exact_ext  = CMP_W'(exact_next);
    sat        = (exact_ext > CMP_W'(srdt_pkg::TOTAL_MAX)) ? srdt_pkg::TOTAL_MAX
                                                            : exact_ext[srdt_pkg::TOTAL_W-1:0];
    conn_next         = conn_bits;
    conn_next[addr_r] = conn_r;
    mask_all   = srdt_pkg::MASK_W'(conn_next[MASK_N-1:0]);
    own_bit    = srdt_pkg::MASK_W'(1) << idx_r;

    first_v  = 1'b0;
    second_v = 1'b0;
    first    = '0;
    second   = '0;
    if (s1_valid && in_range_r) begin
      if (err) begin
        first_v = 1'b1;
        first   = '{dest_mask: '0, total_demand: total, notice_connected: 1'b0,
                    integrity_error: 1'b1, last_notice: 1'b1};
      end else begin
        if (sat != total) begin
          first_v = 1'b1;
          first   = '{dest_mask: mask_all, total_demand: sat, notice_connected: 1'b1,
                      integrity_error: 1'b0, last_notice: !disc};
        end else if (!prev && conn_r) begin
          first_v = 1'b1;
          first   = '{dest_mask: own_bit, total_demand: total, notice_connected: 1'b1,
                      integrity_error: 1'b0, last_notice: 1'b1};
        end
        // disconnect notice goes second if an update notice was issued
        if (disc) begin
          if (first_v) begin
            second_v = 1'b1;
            second   = '{dest_mask: own_bit, total_demand: sat, notice_connected: 1'b0,
                         integrity_error: 1'b0, last_notice: 1'b1};
          end else begin
            first_v = 1'b1;
            first   = '{dest_mask: own_bit, total_demand: sat, notice_connected: 1'b0,
                        integrity_error: 1'b0, last_notice: 1'b1};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      conn_bits    <= '0;
      exact        <= '0;
      total        <= '0;
      result_valid <= 1'b0;
      pend         <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (upd) begin
        conn_bits <= conn_next;
        exact     <= exact_next;
        total     <= sat;
      end
      if (first_v) begin
        result_valid <= 1'b1;
        res          <= first;
        pend         <= second_v;
        pend_n       <= second;
      end else if (pend) begin
        result_valid <= 1'b1;
        res          <= pend_n;
        pend         <= 1'b0;
      end else begin
        result_valid <= 1'b0;
      end
    end
    if (accept) begin
      idx_r      <= client_index;
      conn_r     <= client_connected;
      dem_r      <= DEMAND_BITS'(client_demand);
      in_range_r <= 32'(client_index) < NUM_EXECS;
    end
  end

  assign dest_mask        = res.dest_mask;
  assign total_demand     = res.total_demand;
  assign notice_connected = res.notice_connected;
  assign integrity_error  = res.integrity_error;
  assign last_notice      = res.last_notice;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_notice |=> result_valid)
    else $error("first notice not followed by a second one");

  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && integrity_error |-> last_notice && dest_mask == '0)
    else $error("error result not a lone result with empty mask");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && pend))
    else $error("new report reached update while a notice was pending");

endmodule
